/* rtl/acr_pkg.sv */
// Shared types, codes and constants of the AABB collision resolver.
package acr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int HALF_W        = 31;
    localparam int CFG_IDX_W     = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [HALF_W-1:0]  half_t;

    typedef enum logic [0:0] {
        OP_LOAD    = 1'b0,
        OP_RESOLVE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        CONTACT_NONE = 3'd0,
        CONTACT_X    = 3'd1,
        CONTACT_Z    = 3'd2,
        CONTACT_LAND = 3'd3,
        CONTACT_BONK = 3'd4
    } contact_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_X = 2'd0,
        CFG_HALF_Y = 2'd1,
        CFG_HALF_Z = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        op_t    operation;
        coord_t actor_x;
        coord_t actor_y;
        coord_t actor_z;
        coord_t actor_vel_y;
        logic   actor_on_ground;
        coord_t box_cx;
        coord_t box_cy;
        coord_t box_cz;
        half_t  box_hx;
        half_t  box_hy;
        half_t  box_hz;
    } req_t;

    typedef struct packed {
        coord_t   pos_x;
        coord_t   pos_y;
        coord_t   pos_z;
        coord_t   vel_y;
        logic     on_ground;
        contact_t contact;
    } rsp_t;

endpackage

/* rtl/acr_if.sv */
// Valid/ready channel interfaces for the request and result streams.
interface acr_req_if
    import acr_pkg::*;
();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface acr_rsp_if
    import acr_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/aabb_collision_resolver.sv */
// Top level of the AABB collision resolver: actor state, resolve stage and result register.
//
// The block holds one actor box and pushes it out of solid boxes that arrive one request
// at a time. A load request overwrites the actor position, vertical velocity and on-ground
// flag; a resolve request tests the actor against one box and, on a strict overlap, moves
// it out along the axis of least penetration (ties go to X, then Z, then Y), saturating
// the moved coordinate to 32 bits. Every request gives exactly one result carrying the
// actor state after it and a contact code. A request is taken every cycle while the
// result side is not stalled, and its result passes through the input register, then
// the result register. The rate is set by the single resolve stage, which reads and
// rewrites the actor state as the request moves on, so each request sees the state
// left by the one before it. The input side keeps accepting while a finished result
// waits, until both registers are full.
module aabb_collision_resolver
    import acr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_data,
    acr_req_if.sink              req,
    acr_rsp_if.source            rsp
);

    // Reset value of the actor half extents: 1.0 in the chosen fixed-point format.
    localparam half_t HALF_RESET = half_t'(1) << FRAC_BITS;

    // Result of testing one axis: overlap, penetration depth and side of the box centre.
    typedef struct packed {
        logic                hit;
        logic [COORD_W:0]    pen;
        logic                below;
        logic                above;
    } axis_t;

    // The minimum of the two face penetrations is (sum of half extents) - |centre
    // distance|, and the axis overlaps strictly exactly when that value is positive.
    function automatic axis_t axis_eval(coord_t p, coord_t c, half_t ha, half_t hb);
        logic signed [COORD_W:0]   d;
        logic        [COORD_W:0]   mag;
        logic        [COORD_W:0]   s;
        logic signed [COORD_W+1:0] pen;
        axis_t                     r;
        d       = {p[COORD_W-1], p} - {c[COORD_W-1], c};
        mag     = d[COORD_W] ? (~d + {{COORD_W{1'b0}}, 1'b1}) : d;
        s       = {2'b00, ha} + {2'b00, hb};
        pen     = $signed({1'b0, s}) - $signed({1'b0, mag});
        r.hit   = !pen[COORD_W+1] && (pen != '0);
        r.pen   = pen[COORD_W:0];
        r.below = d[COORD_W];
        r.above = !d[COORD_W] && (d != '0);
        return r;
    endfunction

    // Moves a coordinate by a penetration depth and clamps it to the signed 32-bit range.
    function automatic coord_t move_sat(coord_t p, logic [COORD_W:0] pen, logic down);
        logic signed [COORD_W+2:0] sum;
        logic signed [COORD_W+2:0] step;
        step = {2'b00, pen};
        sum  = down ? ({{3{p[COORD_W-1]}}, p} - step) : ({{3{p[COORD_W-1]}}, p} + step);
        if (sum[COORD_W+2:COORD_W-1] == '0 || sum[COORD_W+2:COORD_W-1] == '1)
        begin
            return sum[COORD_W-1:0];
        end
        return sum[COORD_W+2] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    // Configuration registers.
    half_t half_x_reg;
    half_t half_y_reg;
    half_t half_z_reg;

    // Actor state.
    coord_t pos_x_reg, pos_x_next;
    coord_t pos_y_reg, pos_y_next;
    coord_t pos_z_reg, pos_z_next;
    coord_t vel_y_reg, vel_y_next;
    logic   grounded_reg, grounded_next;

    // Input register and result register.
    logic     in_valid_reg;
    req_t     in_reg;
    logic     out_valid_reg;
    rsp_t     out_reg;
    contact_t contact_next;

    logic  out_free;
    logic  fire;
    logic  in_take;
    axis_t ax, ay, az;
    logic  overlap;
    logic  x_first;
    logic  z_first;

    // The result register frees up when it is empty or its result is being taken; the
    // input register can then hand its request on, so it never blocks on its own.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || fire;
    assign in_take   = req.valid && req.ready;

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_x_reg <= HALF_RESET;
            half_y_reg <= HALF_RESET;
            half_z_reg <= HALF_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_HALF_X: half_x_reg <= cfg_data;
                CFG_HALF_Y: half_y_reg <= cfg_data;
                CFG_HALF_Z: half_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Per-axis overlap test against the current actor state.
    assign ax = axis_eval(pos_x_reg, in_reg.box_cx, half_x_reg, in_reg.box_hx);
    assign ay = axis_eval(pos_y_reg, in_reg.box_cy, half_y_reg, in_reg.box_hy);
    assign az = axis_eval(pos_z_reg, in_reg.box_cz, half_z_reg, in_reg.box_hz);

    assign overlap = ax.hit && ay.hit && az.hit;
    assign x_first = (ax.pen <= ay.pen) && (ax.pen <= az.pen);
    assign z_first = az.pen <= ay.pen;

    always_comb
    begin
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        pos_z_next    = pos_z_reg;
        vel_y_next    = vel_y_reg;
        grounded_next = grounded_reg;
        contact_next  = CONTACT_NONE;

        if (in_reg.operation == OP_LOAD)
        begin
            pos_x_next    = in_reg.actor_x;
            pos_y_next    = in_reg.actor_y;
            pos_z_next    = in_reg.actor_z;
            vel_y_next    = in_reg.actor_vel_y;
            grounded_next = in_reg.actor_on_ground;
        end
        else if (overlap)
        begin
            if (x_first)
            begin
                // Pushed sideways, away from the box centre.
                pos_x_next   = move_sat(pos_x_reg, ax.pen, ax.below);
                contact_next = CONTACT_X;
            end
            else if (z_first)
            begin
                pos_z_next   = move_sat(pos_z_reg, az.pen, az.below);
                contact_next = CONTACT_Z;
            end
            else if (ay.above)
            begin
                // Landing on top: downward motion stops and the actor is grounded.
                pos_y_next    = move_sat(pos_y_reg, ay.pen, 1'b0);
                vel_y_next    = vel_y_reg[COORD_W-1] ? '0 : vel_y_reg;
                grounded_next = 1'b1;
                contact_next  = CONTACT_LAND;
            end
            else
            begin
                // Head bonk: upward motion stops, the grounded flag is kept.
                pos_y_next   = move_sat(pos_y_reg, ay.pen, 1'b1);
                vel_y_next   = (!vel_y_reg[COORD_W-1] && vel_y_reg != '0) ? '0 : vel_y_reg;
                contact_next = CONTACT_BONK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            vel_y_reg     <= '0;
            grounded_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
                pos_z_reg     <= pos_z_next;
                vel_y_reg     <= vel_y_next;
                grounded_reg  <= grounded_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= req.payload;
        end
        if (fire)
        begin
            out_reg.pos_x     <= pos_x_next;
            out_reg.pos_y     <= pos_y_next;
            out_reg.pos_z     <= pos_z_next;
            out_reg.vel_y     <= vel_y_next;
            out_reg.on_ground <= grounded_next;
            out_reg.contact   <= contact_next;
        end
    end

endmodule

/* rtl/acr_checker.sv */
// Port-level assertions for the AABB collision resolver, bound to its top level.
module acr_checker
    import acr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_payload
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("result changed or dropped while stalled");

    // The request side only stalls when a result is waiting and not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request side stalled without back-pressure");

    // A landing leaves the actor grounded with no downward velocity.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.contact == CONTACT_LAND
            |-> rsp_payload.on_ground && !rsp_payload.vel_y[COORD_W-1])
    else $error("landing without ground contact or with downward velocity");

    // A head bonk leaves no upward velocity.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.contact == CONTACT_BONK
            |-> rsp_payload.vel_y[COORD_W-1] || rsp_payload.vel_y == '0)
    else $error("head bonk with upward velocity");

    // After an accepted request the block is either ready again or offering a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !(!req_ready && !rsp_valid))
    else $error("request stall after acceptance without a pending result");

endmodule

bind aabb_collision_resolver acr_checker u_acr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
